>>> sv/dalc_pkg.sv
// shared types and constants for the disk access latency controller
// no dependencies; used by dalc_div and disk_access_latency_controller_core
package dalc_pkg;

  localparam int BLK_W      = 16;  // block number
  localparam int NBLK_W     = 17;  // block count, up to 65536
  localparam int MS_W       = 10;  // delay limits in ms ticks
  localparam int CDOWN_W    = 11;  // countdown
  localparam int RND_W      = 31;  // random word
  localparam int CTR_W      = 32;  // completion counters
  localparam int PROD_W     = BLK_W + MS_W;
  localparam int JIT_W      = 7;   // jitter never exceeds 102
  localparam int SUM_W      = CDOWN_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = NBLK_W;

  // shared serial divider
  localparam int DIV_W      = RND_W;   // dividend and quotient width
  localparam int DVS_W      = NBLK_W;  // divisor and remainder width
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // x / 10 as (x * 205) >> 11, exact for x below 1029
  localparam int RECIP10_W  = 8;
  localparam int RECIP10_SH = 11;
  localparam logic [RECIP10_W-1:0] RECIP10 = 8'd205;

  localparam logic [NBLK_W-1:0] MAX_BLOCKS     = 17'd65536;
  localparam logic [NBLK_W-1:0] NBLK_RESET     = 17'd256;
  localparam logic [MS_W-1:0]   DMIN_RESET     = 10'd30;
  localparam logic [MS_W-1:0]   DMAX_RESET     = 10'd300;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_MAX  = 2'd2;

  typedef enum logic [1:0] {
    DS_UNKNOWN = 2'd0,
    DS_IDLE    = 2'd1,
    DS_READ    = 2'd2,
    DS_WRITE   = 2'd3
  } dev_state_t;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_INIT  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_WRITE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_MOD,
    SQ_QUO,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/dalc_div.sv
// serial restoring divider, one quotient bit per cycle
// depends on dalc_pkg
module dalc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dalc_pkg::DIV_W-1:0]    dividend,
  input  logic [dalc_pkg::DVS_W-1:0]    divisor,
  output dalc_pkg::div_stat_t           stat,
  output logic [dalc_pkg::DIV_W-1:0]    quotient,
  output logic [dalc_pkg::DVS_W-1:0]    remainder
);

  localparam logic [dalc_pkg::DIV_CNT_W-1:0] LAST_STEP =
    dalc_pkg::DIV_CNT_W'(dalc_pkg::DIV_W - 1);

  logic                           busy_r;
  logic                           done_r;
  logic [dalc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [dalc_pkg::DIV_W-1:0]     quo_r;
  logic [dalc_pkg::DVS_W-1:0]     rem_r;
  logic [dalc_pkg::DVS_W-1:0]     dvs_r;

  logic [dalc_pkg::DVS_W:0]       trial;
  logic [dalc_pkg::DVS_W:0]       diff;
  logic                           qbit;
  logic [dalc_pkg::DVS_W-1:0]     rem_nxt;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[dalc_pkg::DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? diff[dalc_pkg::DVS_W-1:0] : trial[dalc_pkg::DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[dalc_pkg::DIV_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("done without a finished pass");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r && cnt_r == '0)
    else $error("divider did not start");
`endif

endmodule

>>> sv/disk_access_latency_controller_core.sv
// disk access latency controller: status, countdown and completion counters,
// seek delay computed on the shared serial divider; depends on dalc_pkg, dalc_div
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    req_type, block_index, buffer_valid, random_word
//  out_     output     out_valid / out_stall  error, disk_state, reads_done, writes_done,
//                                             done_irq, done_block
//  cfg_     input      cfg_we                 cfg_index, cfg_wdata
//
// a tick, an init or a rejected request is handled without the divider; its result is registered
// an accepted read or write request goes through MUL, MOD, QUO and DONE: two 31-step divider
// passes (jitter modulo, seek scaling); the first pass is skipped when max does not exceed min
// one transaction at a time; in_stall is high while a request is in flight
// or while the output register holds a result that out_stall keeps
// synchronous active-low reset; configuration returns to 256 blocks, 30 and 300 ms
module disk_access_latency_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_req_type,
  input  logic [dalc_pkg::BLK_W-1:0]          in_block_index,
  input  logic                                in_buffer_valid,
  input  logic [dalc_pkg::RND_W-1:0]          in_random_word,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_error,
  output logic [1:0]                          out_disk_state,
  output logic [dalc_pkg::CTR_W-1:0]          out_reads_done,
  output logic [dalc_pkg::CTR_W-1:0]          out_writes_done,
  output logic                                out_done_irq,
  output logic [dalc_pkg::BLK_W-1:0]          out_done_block,

  input  logic                                cfg_we,
  input  logic [dalc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dalc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // configuration
  logic [dalc_pkg::NBLK_W-1:0]  nblk_cfg_r;
  logic [dalc_pkg::MS_W-1:0]    dmin_r;
  logic [dalc_pkg::MS_W-1:0]    dmax_r;

  // device state
  dalc_pkg::dev_state_t         status_r;
  logic [dalc_pkg::BLK_W-1:0]   last_blk_r;
  logic [dalc_pkg::BLK_W-1:0]   pend_blk_r;
  logic [dalc_pkg::CDOWN_W-1:0] cdown_r;
  logic [dalc_pkg::CTR_W-1:0]   rd_ctr_r;
  logic [dalc_pkg::CTR_W-1:0]   wr_ctr_r;

  // request in flight
  dalc_pkg::seq_state_t         seq_r;
  dalc_pkg::seq_state_t         seq_nxt;
  dalc_pkg::dev_state_t         job_kind_r;
  logic [dalc_pkg::BLK_W-1:0]   job_blk_r;
  logic [dalc_pkg::RND_W-1:0]   job_rnd_r;
  logic [dalc_pkg::BLK_W-1:0]   dist_r;
  logic [dalc_pkg::MS_W-1:0]    span_r;
  logic [dalc_pkg::NBLK_W-1:0]  nblk_r;
  logic [dalc_pkg::PROD_W-1:0]  prod_r;
  logic [dalc_pkg::JIT_W-1:0]   jit_r;
  // seek quotient exceeds span when the last block lies past a shrunken block range
  logic [dalc_pkg::CDOWN_W-1:0] quo_r;

  // output register
  logic                         out_valid_r;
  logic                         out_error_r;
  dalc_pkg::dev_state_t         out_state_r;
  logic [dalc_pkg::CTR_W-1:0]   out_rd_r;
  logic [dalc_pkg::CTR_W-1:0]   out_wr_r;
  logic                         out_irq_r;
  logic [dalc_pkg::BLK_W-1:0]   out_dblk_r;

  // immediate item outcome
  dalc_pkg::dev_state_t         status_nxt;
  logic [dalc_pkg::BLK_W-1:0]   last_blk_nxt;
  logic [dalc_pkg::BLK_W-1:0]   pend_blk_nxt;
  logic [dalc_pkg::CDOWN_W-1:0] cdown_nxt;
  logic [dalc_pkg::CTR_W-1:0]   rd_ctr_nxt;
  logic [dalc_pkg::CTR_W-1:0]   wr_ctr_nxt;
  logic                         err_nxt;
  logic                         irq_nxt;
  logic [dalc_pkg::BLK_W-1:0]   dblk_nxt;

  dalc_pkg::req_t               req_c;
  logic                         is_req;
  logic [dalc_pkg::NBLK_W-1:0]  eff_nblk;
  logic [dalc_pkg::MS_W-1:0]    span_c;
  logic [dalc_pkg::BLK_W-1:0]   dist_c;
  logic                         req_ok;
  logic                         in_fire;
  logic                         job_fire;
  logic                         imm_fire;
  logic                         out_free;
  logic                         commit;

  // divider hookup
  logic                         div_start;
  logic [dalc_pkg::DIV_W-1:0]   div_dividend;
  logic [dalc_pkg::DVS_W-1:0]   div_divisor;
  dalc_pkg::div_stat_t          div_stat;
  logic [dalc_pkg::DIV_W-1:0]   div_quo;
  logic [dalc_pkg::DVS_W-1:0]   div_rem;

  logic [dalc_pkg::MS_W+dalc_pkg::RECIP10_W-1:0] jit_prod;
  logic [dalc_pkg::SUM_W-1:0]   delay_sum;

  dalc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nblk_cfg_r <= dalc_pkg::NBLK_RESET;
      dmin_r     <= dalc_pkg::DMIN_RESET;
      dmax_r     <= dalc_pkg::DMAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dalc_pkg::CFG_NUM_BLOCKS: nblk_cfg_r <= cfg_wdata;
        dalc_pkg::CFG_DELAY_MIN:  dmin_r     <= cfg_wdata[dalc_pkg::MS_W-1:0];
        dalc_pkg::CFG_DELAY_MAX:  dmax_r     <= cfg_wdata[dalc_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  // request checks and seek distance
  always_comb begin
    req_c    = dalc_pkg::req_t'(in_req_type);
    is_req   = (req_c == dalc_pkg::REQ_READ) || (req_c == dalc_pkg::REQ_WRITE);
    eff_nblk = (nblk_cfg_r > dalc_pkg::MAX_BLOCKS) ? dalc_pkg::MAX_BLOCKS : nblk_cfg_r;
    span_c   = (dmax_r > dmin_r) ? (dmax_r - dmin_r) : '0;
    dist_c   = (in_block_index >= last_blk_r) ? (in_block_index - last_blk_r)
                                              : (last_blk_r - in_block_index);
    req_ok   = (status_r == dalc_pkg::DS_IDLE) && in_buffer_valid
               && ({1'b0, in_block_index} < eff_nblk);
  end

  // tick, init and rejected requests resolve at once
  always_comb begin
    status_nxt   = status_r;
    last_blk_nxt = last_blk_r;
    pend_blk_nxt = pend_blk_r;
    cdown_nxt    = cdown_r;
    rd_ctr_nxt   = rd_ctr_r;
    wr_ctr_nxt   = wr_ctr_r;
    err_nxt      = 1'b0;
    irq_nxt      = 1'b0;
    dblk_nxt     = '0;
    unique case (req_c)
      dalc_pkg::REQ_TICK: begin
        if (status_r == dalc_pkg::DS_READ || status_r == dalc_pkg::DS_WRITE) begin
          if (cdown_r <= dalc_pkg::CDOWN_W'(1)) begin
            cdown_nxt = '0;
            if (status_r == dalc_pkg::DS_READ) begin
              rd_ctr_nxt = rd_ctr_r + 1'b1;
            end else begin
              wr_ctr_nxt = wr_ctr_r + 1'b1;
            end
            last_blk_nxt = pend_blk_r;
            status_nxt   = dalc_pkg::DS_IDLE;
            irq_nxt      = 1'b1;
            dblk_nxt     = pend_blk_r;
          end else begin
            cdown_nxt = cdown_r - 1'b1;
          end
        end
      end
      dalc_pkg::REQ_INIT: begin
        if (status_r != dalc_pkg::DS_UNKNOWN) begin
          err_nxt = 1'b1;
        end else begin
          status_nxt   = dalc_pkg::DS_IDLE;
          last_blk_nxt = '0;
          pend_blk_nxt = '0;
          cdown_nxt    = '0;
          rd_ctr_nxt   = '0;
          wr_ctr_nxt   = '0;
        end
      end
      dalc_pkg::REQ_READ, dalc_pkg::REQ_WRITE: begin
        err_nxt = !req_ok;
      end
      default: ;
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign job_fire = in_fire && is_req && req_ok;
  assign imm_fire = in_fire && !(is_req && req_ok);

  // sequencer next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      dalc_pkg::SQ_IDLE: if (job_fire) seq_nxt = dalc_pkg::SQ_MUL;
      dalc_pkg::SQ_MUL:  seq_nxt = dalc_pkg::SQ_MOD;
      dalc_pkg::SQ_MOD:  if (span_r == '0 || div_stat.done) seq_nxt = dalc_pkg::SQ_QUO;
      dalc_pkg::SQ_QUO:  if (div_stat.done) seq_nxt = dalc_pkg::SQ_DONE;
      dalc_pkg::SQ_DONE: if (out_free) seq_nxt = dalc_pkg::SQ_IDLE;
      default:           seq_nxt = dalc_pkg::SQ_IDLE;
    endcase
  end

  // sequencer outputs: first pass is random mod span (skipped when span is zero), second is product / blocks
  always_comb begin
    in_stall     = (seq_r != dalc_pkg::SQ_IDLE) || !out_free;
    div_start    = 1'b0;
    div_dividend = dalc_pkg::DIV_W'(prod_r);
    div_divisor  = nblk_r;
    commit       = 1'b0;
    unique case (seq_r)
      dalc_pkg::SQ_MUL: begin
        div_start    = (span_r != '0);
        div_dividend = job_rnd_r;
        div_divisor  = dalc_pkg::DVS_W'(span_r);
      end
      dalc_pkg::SQ_MOD: begin
        div_start = (span_r == '0) || div_stat.done;
      end
      dalc_pkg::SQ_DONE: begin
        commit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= dalc_pkg::SQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  assign jit_prod  = div_rem[dalc_pkg::MS_W-1:0] * dalc_pkg::RECIP10;
  assign delay_sum = dalc_pkg::SUM_W'(quo_r) + dalc_pkg::SUM_W'(dmin_r)
                     + dalc_pkg::SUM_W'(jit_r);

  // request datapath
  always_ff @(posedge clk) begin
    if (job_fire) begin
      job_kind_r <= (req_c == dalc_pkg::REQ_READ) ? dalc_pkg::DS_READ : dalc_pkg::DS_WRITE;
      job_blk_r  <= in_block_index;
      job_rnd_r  <= in_random_word;
      dist_r     <= dist_c;
      span_r     <= span_c;
      nblk_r     <= eff_nblk;
    end
    if (seq_r == dalc_pkg::SQ_MUL) begin
      prod_r <= dist_r * span_r;
    end
    if (seq_r == dalc_pkg::SQ_MOD) begin
      jit_r <= (span_r == '0) ? '0
               : jit_prod[dalc_pkg::RECIP10_SH +: dalc_pkg::JIT_W];
    end
    if (seq_r == dalc_pkg::SQ_QUO && div_stat.done) begin
      quo_r <= div_quo[dalc_pkg::CDOWN_W-1:0];
    end
  end

  // device state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= dalc_pkg::DS_UNKNOWN;
      last_blk_r <= '0;
      pend_blk_r <= '0;
      cdown_r    <= '0;
      rd_ctr_r   <= '0;
      wr_ctr_r   <= '0;
    end else if (imm_fire) begin
      status_r   <= status_nxt;
      last_blk_r <= last_blk_nxt;
      pend_blk_r <= pend_blk_nxt;
      cdown_r    <= cdown_nxt;
      rd_ctr_r   <= rd_ctr_nxt;
      wr_ctr_r   <= wr_ctr_nxt;
    end else if (commit) begin
      status_r   <= job_kind_r;
      pend_blk_r <= job_blk_r;
      cdown_r    <= delay_sum[dalc_pkg::CDOWN_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (imm_fire || commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_fire) begin
      out_error_r <= err_nxt;
      out_state_r <= status_nxt;
      out_rd_r    <= rd_ctr_nxt;
      out_wr_r    <= wr_ctr_nxt;
      out_irq_r   <= irq_nxt;
      out_dblk_r  <= dblk_nxt;
    end else if (commit) begin
      out_error_r <= 1'b0;
      out_state_r <= job_kind_r;
      out_rd_r    <= rd_ctr_r;
      out_wr_r    <= wr_ctr_r;
      out_irq_r   <= 1'b0;
      out_dblk_r  <= '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_error       = out_error_r;
  assign out_disk_state  = out_state_r;
  assign out_reads_done  = out_rd_r;
  assign out_writes_done = out_wr_r;
  assign out_done_irq    = out_irq_r;
  assign out_done_block  = out_dblk_r;

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r != dalc_pkg::SQ_IDLE |-> in_stall)
    else $error("input taken while a request is in flight");

  a_job_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_fire |-> status_r == dalc_pkg::DS_IDLE)
    else $error("request started while device not idle");

  a_commit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r
      && (status_r == dalc_pkg::DS_READ || status_r == dalc_pkg::DS_WRITE))
    else $error("commit did not leave an operation pending");

  a_div_idle_between: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == dalc_pkg::SQ_IDLE |-> !div_stat.busy)
    else $error("divider busy with no request in flight");
`endif

endmodule
